@@ sv/rgbyc_pkg.sv @@
// Shared types and constants for the RGB to YCbCr 4:2:0 converter.
// Depends on nothing; every other file of the block imports it.
package rgbyc_pkg;

  // Largest frame dimension in pixels; the counters and size clamps follow it.
  localparam int MAX_DIMENSION = 4096;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
  localparam int DIM_W     = $clog2(MAX_DIMENSION + 1);
  localparam int CMP_W     = (DIM_W > CFG_W) ? DIM_W : CFG_W;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Fixed-point color matrix: Q16 coefficients, accumulator wide enough for
  // the full signed sum plus the offset.
  localparam int Q_SHIFT = 16;
  localparam int ACC_W   = 26;

  localparam logic signed [ACC_W-1:0] K_YR   = ACC_W'(16843);
  localparam logic signed [ACC_W-1:0] K_YG   = ACC_W'(33030);
  localparam logic signed [ACC_W-1:0] K_YB   = ACC_W'(6423);
  localparam logic signed [ACC_W-1:0] K_CR_R = ACC_W'(28770);
  localparam logic signed [ACC_W-1:0] K_CR_G = ACC_W'(24117);
  localparam logic signed [ACC_W-1:0] K_CR_B = ACC_W'(4653);
  localparam logic signed [ACC_W-1:0] K_CB_R = ACC_W'(9699);
  localparam logic signed [ACC_W-1:0] K_CB_G = ACC_W'(19071);
  localparam logic signed [ACC_W-1:0] K_CB_B = ACC_W'(28770);

  localparam logic signed [ACC_W-1:0] OFS_Y = ACC_W'(16 << Q_SHIFT);
  localparam logic signed [ACC_W-1:0] OFS_C = ACC_W'(128 << Q_SHIFT);

  // Position flags of one pixel, passed from the raster tracker to the datapath.
  typedef struct packed {
    logic chroma_valid;
    logic frame_end;
  } pos_flags_t;

endpackage

@@ sv/rgbyc_position.sv @@
// Raster position tracker: frame size registers, column and row counters.
// Depends on rgbyc_pkg.
module rgbyc_position (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rgbyc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbyc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            advance,
  output rgbyc_pkg::pos_flags_t           flags
);
  import rgbyc_pkg::*;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [CMP_W-1:0] eff_width;
  logic [CMP_W-1:0] eff_height;
  logic             last_col;
  logic             last_row;

  // Zero is taken as one, anything above the maximum as the maximum.
  function automatic logic [CMP_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(v);
    if (v == '0) begin
      return CMP_W'(1);
    end else if (wide > CMP_W'(MAX_DIMENSION)) begin
      return CMP_W'(MAX_DIMENSION);
    end
    return wide;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_width  = eff_size(frame_width);
    eff_height = eff_size(frame_height);
    last_col   = (CMP_W'(column_count) + CMP_W'(1)) >= eff_width;
    last_row   = (CMP_W'(row_count) + CMP_W'(1)) >= eff_height;
    flags.chroma_valid = column_count[0] & row_count[0];
    flags.frame_end    = last_col & last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/rgbyc_matrix.sv @@
// Fixed-point BT.601 color matrix with clamping to 0..255.
// Depends on rgbyc_pkg.
module rgbyc_matrix (
  input  logic [rgbyc_pkg::PIX_W-1:0] red,
  input  logic [rgbyc_pkg::PIX_W-1:0] green,
  input  logic [rgbyc_pkg::PIX_W-1:0] blue,
  output logic [rgbyc_pkg::PIX_W-1:0] luma,
  output logic [rgbyc_pkg::PIX_W-1:0] chroma_blue,
  output logic [rgbyc_pkg::PIX_W-1:0] chroma_red
);
  import rgbyc_pkg::*;

  logic signed [ACC_W-1:0] r_ext;
  logic signed [ACC_W-1:0] g_ext;
  logic signed [ACC_W-1:0] b_ext;
  logic signed [ACC_W-1:0] y_acc;
  logic signed [ACC_W-1:0] cb_acc;
  logic signed [ACC_W-1:0] cr_acc;

  // Negative sums give zero; the integer part saturates at 255.
  function automatic logic [PIX_W-1:0] to_byte(input logic signed [ACC_W-1:0] acc);
    if (acc[ACC_W-1]) begin
      return '0;
    end else if (|acc[ACC_W-2:Q_SHIFT+PIX_W]) begin
      return '1;
    end
    return acc[Q_SHIFT+PIX_W-1:Q_SHIFT];
  endfunction

  always_comb begin
    r_ext  = signed'(ACC_W'(red));
    g_ext  = signed'(ACC_W'(green));
    b_ext  = signed'(ACC_W'(blue));
    y_acc  = K_YR * r_ext + K_YG * g_ext + K_YB * b_ext + OFS_Y;
    cb_acc = K_CB_B * b_ext - K_CB_R * r_ext - K_CB_G * g_ext + OFS_C;
    cr_acc = K_CR_R * r_ext - K_CR_G * g_ext - K_CR_B * b_ext + OFS_C;
    luma        = to_byte(y_acc);
    chroma_blue = to_byte(cb_acc);
    chroma_red  = to_byte(cr_acc);
  end

endmodule

@@ sv/rgb_to_ycbcr420_converter_top.sv @@
// RGB to YCbCr 4:2:0 converter, top level. The input register and the result
// register around the matrix lie between input transfer and presented result;
// they set a throughput of one pixel per cycle while out_ready is high.
// Reset (synchronous, active high) empties the pipeline, clears the raster
// counters and loads the frame size registers with 640 by 480.
// Depends on rgbyc_pkg, rgbyc_position and rgbyc_matrix.
module rgb_to_ycbcr420_converter_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rgbyc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbyc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rgbyc_pkg::PIX_W-1:0]     red,
  input  logic [rgbyc_pkg::PIX_W-1:0]     green,
  input  logic [rgbyc_pkg::PIX_W-1:0]     blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rgbyc_pkg::PIX_W-1:0]     luma,
  output logic [rgbyc_pkg::PIX_W-1:0]     chroma_blue,
  output logic [rgbyc_pkg::PIX_W-1:0]     chroma_red,
  output logic                            chroma_valid,
  output logic                            frame_end
);
  import rgbyc_pkg::*;

  // The pipeline has two registered stages: the input register captures the
  // pixel together with its raster flags, and the result register holds the
  // converted pixel until the output transfer takes it. Each stage moves on
  // when the stage after it is empty or is being emptied in the same cycle,
  // so with out_ready high a full pipeline keeps one transfer per cycle per side.
  logic             in_xfer;
  logic             s1_advance;
  logic             out_advance;
  logic             s1_valid;
  logic [PIX_W-1:0] s1_red;
  logic [PIX_W-1:0] s1_green;
  logic [PIX_W-1:0] s1_blue;
  pos_flags_t       s1_flags;
  pos_flags_t       cur_flags;
  logic [PIX_W-1:0] m_luma;
  logic [PIX_W-1:0] m_cb;
  logic [PIX_W-1:0] m_cr;

  assign out_advance = ~out_valid | out_ready;
  assign s1_advance  = ~s1_valid | out_advance;
  assign in_ready    = s1_advance;
  assign in_xfer     = in_valid & in_ready;

  // The raster counters step once per accepted pixel; the flags they give
  // belong to the pixel being accepted.
  rgbyc_position u_position (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (in_xfer),
    .flags     (cur_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_red   <= red;
      s1_green <= green;
      s1_blue  <= blue;
      s1_flags <= cur_flags;
    end
  end

  rgbyc_matrix u_matrix (
    .red         (s1_red),
    .green       (s1_green),
    .blue        (s1_blue),
    .luma        (m_luma),
    .chroma_blue (m_cb),
    .chroma_red  (m_cr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= s1_valid;
    end
  end

  // Chroma is forced to zero on every pixel that is not the odd-row,
  // odd-column sample of its 2x2 block.
  always_ff @(posedge clk) begin
    if (out_advance && s1_valid) begin
      luma         <= m_luma;
      chroma_blue  <= s1_flags.chroma_valid ? m_cb : '0;
      chroma_red   <= s1_flags.chroma_valid ? m_cr : '0;
      chroma_valid <= s1_flags.chroma_valid;
      frame_end    <= s1_flags.frame_end;
    end
  end

endmodule
